// ----- hw/rtl/alrcg_pkg.sv -----
// ----------------------------------------------------------------------------
// alrcg_pkg: shared types and constants for the array LDPC row generator
// Field widths, register codes, controller states and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package alrcg_pkg;

  // field widths
  localparam int RowW      = 12;
  localparam int ColW      = 12;
  localparam int PrimeW    = 7;
  localparam int BlkCntW   = 6;   // j, k register width
  localparam int BlkW      = 5;   // block index width
  localparam int StepW     = 3;   // restoring divider step counter
  localparam int SqW       = 13;  // j * p product
  localparam int TdataW    = 16;
  localparam int TuserW    = 2;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 7;

  localparam logic [BlkCntW-1:0] MaxBlocks   = 6'd32;
  localparam logic [StepW-1:0]   FirstStep   = 3'd4;   // quotient < 32
  localparam logic [PrimeW-1:0]  PrimeReset  = 7'd7;
  localparam logic [BlkCntW-1:0] RowBlkReset = 6'd3;
  localparam logic [BlkCntW-1:0] ColBlkReset = 6'd6;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_PRIME_SIZE = 2'd0,
    CFG_ROW_BLOCKS = 2'd1,
    CFG_COL_BLOCKS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_MOD_BK,
    ST_MOD_BP,
    ST_SET_W0,
    ST_MOD_W0,
    ST_EMIT,
    ST_FLAG
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_END_ROW,
    OP_END_BK,
    OP_END_BP,
    OP_SET_W0,
    OP_END_W0,
    OP_EMIT,
    OP_FLAG
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad_row;    // incoming row index outside the j*p square, or p is zero
    logic k_zero;     // no column blocks
    logic step_last;  // divider on its final step
    logic emit_last;  // emitting the last column block
    logic out_free;   // output register can take an item
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/alrcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// alrcg_ctrl: sequencing state machine
// Steps the datapath through row division, the three modulo reductions
// and the per-column-block emit loop.
// ----------------------------------------------------------------------------
`default_nettype none

module alrcg_ctrl import alrcg_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = (stat_i.bad_row || stat_i.k_zero) ? ST_FLAG : ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (stat_i.step_last) begin
          cmd_o.op = OP_END_ROW;
          state_d  = ST_MOD_BK;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      ST_MOD_BK: begin
        if (stat_i.step_last) begin
          cmd_o.op = OP_END_BK;
          state_d  = ST_MOD_BP;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      ST_MOD_BP: begin
        if (stat_i.step_last) begin
          cmd_o.op = OP_END_BP;
          state_d  = ST_SET_W0;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      ST_SET_W0: begin
        cmd_o.op = OP_SET_W0;
        state_d  = ST_MOD_W0;
      end
      ST_MOD_W0: begin
        if (stat_i.step_last) begin
          cmd_o.op = OP_END_W0;
          state_d  = ST_EMIT;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLAG: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FLAG;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/alrcg_dp.sv -----
// ----------------------------------------------------------------------------
// alrcg_dp: configuration, shared divider and column generation
// Restoring divider (5 quotient bits, one per cycle) shared by all
// reductions; incremental column walk; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alrcg_dp import alrcg_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [CfgAddrW-1:0] cfg_addr_i,
  input  wire  [CfgDataW-1:0] cfg_wdata_i,
  input  wire  [RowW-1:0]     row_index_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [ColW-1:0]     column_index_o,
  output logic                has_column_o,
  output logic                row_invalid_o,
  output logic                last_o
);

  // configuration
  logic [PrimeW-1:0]  prime_q;
  logic [BlkCntW-1:0] row_blk_q, col_blk_q;
  logic [BlkCntW-1:0] j_eff, k_eff, k_lst;
  logic [SqW-1:0]     square;

  // working registers
  logic [RowW-1:0]   r_q, rem_q, base_q;
  logic [PrimeW-1:0] div_q, ii_q, bnp_q, w_q;
  logic [BlkW-1:0]   quo_q, bn_q, bk_q, b_q, fb_q;
  logic [StepW-1:0]  step_q;
  logic              inv_q;

  // output register
  logic              out_valid_q;
  logic [ColW-1:0]   col_out_q;
  logic              has_out_q, inv_out_q, last_out_q;

  // divider step
  logic [RowW-1:0] shifted, rem_n;
  logic [BlkW-1:0] quo_n;
  logic            ge;

  // emit path
  logic [ColW-1:0]   col;
  logic              drop, wrap, load_out;
  logic [PrimeW:0]   w_sum;
  logic [PrimeW-1:0] w_inc;
  logic [BlkW-1:0]   b0;
  logic [BlkCntW-1:0] b0_wide;
  logic [RowW-1:0]   w0_sum;

  always_comb begin
    j_eff  = (row_blk_q > MaxBlocks) ? MaxBlocks : row_blk_q;
    k_eff  = (col_blk_q > MaxBlocks) ? MaxBlocks : col_blk_q;
    k_lst  = k_eff - 6'd1;
    square = SqW'(j_eff) * SqW'(prime_q);

    shifted = RowW'(div_q) << step_q;
    ge      = (rem_q >= shifted);
    rem_n   = ge ? (rem_q - shifted) : rem_q;
    quo_n   = ge ? (quo_q | (BlkW'(1) << step_q)) : quo_q;

    // first source block: (-bn) mod k
    b0_wide = (bk_q == '0) ? '0 : (k_eff - BlkCntW'(bk_q));
    b0      = b0_wide[BlkW-1:0];
    w0_sum  = RowW'(ii_q) + RowW'(bnp_q) * RowW'(b_q);

    col   = base_q + ColW'(w_q);
    drop  = (col < r_q);     // row is inside the square, so this is the triangle rule
    wrap  = ({1'b0, b_q} == k_lst);
    w_sum = {1'b0, w_q} + {1'b0, bnp_q};
    w_inc = (w_sum >= {1'b0, prime_q}) ? PrimeW'(w_sum - {1'b0, prime_q})
                                       : w_sum[PrimeW-1:0];

    stat_o.bad_row   = ({1'b0, row_index_i} >= square) || (prime_q == '0);
    stat_o.k_zero    = (k_eff == '0);
    stat_o.step_last = (step_q == '0);
    stat_o.emit_last = ({1'b0, fb_q} == k_lst);
    stat_o.out_free  = !out_valid_q || out_ready_i;

    load_out = ((cmd_i.op == OP_EMIT) && (!drop || stat_o.emit_last)) ||
               (cmd_i.op == OP_FLAG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q     <= PrimeReset;
      row_blk_q   <= RowBlkReset;
      col_blk_q   <= ColBlkReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_PRIME_SIZE: prime_q   <= cfg_wdata_i;
          CFG_ROW_BLOCKS: row_blk_q <= cfg_wdata_i[BlkCntW-1:0];
          CFG_COL_BLOCKS: col_blk_q <= cfg_wdata_i[BlkCntW-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        r_q    <= row_index_i;
        rem_q  <= row_index_i;
        div_q  <= prime_q;
        step_q <= FirstStep;
        quo_q  <= '0;
        inv_q  <= stat_o.bad_row;
      end
      OP_STEP: begin
        rem_q  <= rem_n;
        quo_q  <= quo_n;
        step_q <= step_q - 3'd1;
      end
      OP_END_ROW: begin
        bn_q   <= quo_n;
        ii_q   <= rem_n[PrimeW-1:0];
        rem_q  <= RowW'(quo_n);
        div_q  <= PrimeW'(k_eff);
        step_q <= FirstStep;
        quo_q  <= '0;
      end
      OP_END_BK: begin
        bk_q   <= rem_n[BlkW-1:0];
        rem_q  <= RowW'(bn_q);
        div_q  <= prime_q;
        step_q <= FirstStep;
        quo_q  <= '0;
      end
      OP_END_BP: begin
        bnp_q <= rem_n[PrimeW-1:0];
        b_q   <= b0;
      end
      OP_SET_W0: begin
        rem_q  <= w0_sum;
        div_q  <= prime_q;
        step_q <= FirstStep;
        quo_q  <= '0;
      end
      OP_END_W0: begin
        w_q    <= rem_n[PrimeW-1:0];
        fb_q   <= '0;
        base_q <= '0;
      end
      OP_EMIT: begin
        fb_q   <= fb_q + 5'd1;
        base_q <= base_q + RowW'(prime_q);
        b_q    <= wrap ? '0 : (b_q + 5'd1);
        w_q    <= wrap ? ii_q : w_inc;
        if (!drop) begin
          col_out_q  <= col;
          has_out_q  <= 1'b1;
          inv_out_q  <= 1'b0;
          last_out_q <= stat_o.emit_last;
        end else if (stat_o.emit_last) begin
          // every column fell below the diagonal: empty row
          col_out_q  <= '0;
          has_out_q  <= 1'b0;
          inv_out_q  <= 1'b0;
          last_out_q <= 1'b1;
        end
      end
      OP_FLAG: begin
        col_out_q  <= '0;
        has_out_q  <= 1'b0;
        inv_out_q  <= inv_q;
        last_out_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign column_index_o = col_out_q;
  assign has_column_o   = has_out_q;
  assign row_invalid_o  = inv_out_q;
  assign last_o         = last_out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/array_ldpc_row_column_generator_top.sv -----
// ----------------------------------------------------------------------------
// array_ldpc_row_column_generator_top: modified array LDPC H row generator
// Lists the columns holding a one in a requested parity-check row.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one row index per item. For each accepted row the
//    master stream returns the column of every one in that row in ascending
//    order, tlast on the final item. An empty row (every column below the
//    diagonal, or no column blocks) or a row outside the j*p square gives a
//    single item with has_column low (and row_invalid high if outside).
//  - Config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
//    (0 prime_size, 1 row_blocks, 2 col_blocks); write only while idle.
//    row_blocks and col_blocks keep wdata bits [5:0]; 33 to 63 act as 32.
//  - One row at a time. Per row: an accept step, three divisions (row / p,
//    bn mod k, bn mod p), a setup step and a fourth reduction for the first
//    column offset on the shared restoring divider, then one cycle per column
//    block in the emit loop while the master side takes items. Bad rows and
//    k = 0 go from accept straight to a single flag item.
//  - A one-entry output register separates the sides: a new row is accepted
//    while the previous final item still waits. A stalled master side holds
//    the emit loop; nothing is dropped.
//  - Reset (rst_ni low, async) clears the controller and output valid and
//    restores p = 7, j = 3, k = 6.
// ----------------------------------------------------------------------------
`default_nettype none

module array_ldpc_row_column_generator_top import alrcg_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // config write port
  input  wire                 cfg_we_i,
  input  wire  [CfgAddrW-1:0] cfg_addr_i,
  input  wire  [CfgDataW-1:0] cfg_wdata_i,
  // row index stream
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [TdataW-1:0]   s_axis_tdata,   // [11:0] row_index, [15:12] ignored
  // column stream
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [TdataW-1:0]   m_axis_tdata,   // [11:0] column_index, [15:12] zero
  output logic [TuserW-1:0]   m_axis_tuser,   // [0] has_column, [1] row_invalid
  output logic                m_axis_tlast
);

  cmd_t            cmd;
  stat_t           stat;
  logic [ColW-1:0] column_index;
  logic            has_column, row_invalid;

  alrcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  alrcg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .row_index_i    (s_axis_tdata[RowW-1:0]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .column_index_o (column_index),
    .has_column_o   (has_column),
    .row_invalid_o  (row_invalid),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TdataW-ColW){1'b0}}, column_index};
  assign m_axis_tuser = {row_invalid, has_column};

endmodule

`default_nettype wire
